// ===== rtl/arx_pkg.sv =====
`default_nettype none

package arx_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ROT_X   = 7;
    localparam int unsigned ROT_Y   = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  action;
        t_word in_word_low;
        t_word in_word_high;
    } t_cmd_word;

    typedef struct packed {
        t_word out_word_low;
        t_word out_word_high;
    } t_result_word;

    // one block in flight with its own copy of the key schedule
    typedef struct packed {
        logic  dec;
        t_word x;
        t_word y;
        t_word a;
        t_word b;
    } t_lane;

    typedef struct packed {
        t_word x;
        t_word y;
    } t_pair;

    function automatic t_word ror_w(input t_word v, input int unsigned r);
        ror_w = (v >> r) | (v << (WORD_W - r));
    endfunction

    function automatic t_word rol_w(input t_word v, input int unsigned r);
        rol_w = (v << r) | (v >> (WORD_W - r));
    endfunction

    function automatic t_pair arx_fwd(input t_pair p, input t_word k);
        t_word s;
        s = (ror_w(p.x, ROT_X) + p.y) ^ k;
        arx_fwd.x = s;
        arx_fwd.y = rol_w(p.y, ROT_Y) ^ s;
    endfunction

    function automatic t_pair arx_inv(input t_pair p, input t_word k);
        t_word t;
        t = ror_w(p.y ^ p.x, ROT_Y);
        arx_inv.x = rol_w((p.x ^ k) - t, ROT_X);
        arx_inv.y = t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/arx_sched_cell.sv =====
`default_nettype none

module arx_sched_cell
    import arx_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    localparam t_word SCHED_KEY = t_word'(IDX);

    logic  r_valid;
    t_lane r_lane;
    t_lane n_lane;
    t_pair w_sched;

    // forward schedule step, decrypt words only; encrypt words ride through
    always_comb begin
        w_sched = arx_fwd(t_pair'{x: i_lane.a, y: i_lane.b}, SCHED_KEY);
        n_lane  = i_lane;
        if (i_lane.dec == ACT_DECRYPT) begin
            n_lane.a = w_sched.x;
            n_lane.b = w_sched.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

`default_nettype wire

// ===== rtl/arx_round_cell.sv =====
`default_nettype none

module arx_round_cell
    import arx_pkg::*;
#(
    parameter int ROUND_COUNT = 16,
    parameter int IDX         = 0
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    localparam t_word FWD_KEY  = t_word'(IDX);
    localparam bit    HAS_BACK = (IDX < ROUND_COUNT - 1);
    localparam t_word BACK_KEY = HAS_BACK ? t_word'(ROUND_COUNT - 2 - IDX) : '0;

    logic  r_valid;
    t_lane r_lane;
    t_lane n_lane;
    t_pair w_data_fwd;
    t_pair w_data_inv;
    t_pair w_key_fwd;
    t_pair w_key_inv;

    always_comb begin
        w_data_fwd = arx_fwd(t_pair'{x: i_lane.x, y: i_lane.y}, i_lane.b);
        w_data_inv = arx_inv(t_pair'{x: i_lane.x, y: i_lane.y}, i_lane.b);
        w_key_fwd  = arx_fwd(t_pair'{x: i_lane.a, y: i_lane.b}, FWD_KEY);
        w_key_inv  = arx_inv(t_pair'{x: i_lane.a, y: i_lane.b}, BACK_KEY);
        n_lane     = i_lane;
        if (i_lane.dec == ACT_DECRYPT) begin
            n_lane.x = w_data_inv.x;
            n_lane.y = w_data_inv.y;
            if (HAS_BACK) begin
                n_lane.a = w_key_inv.x;
                n_lane.b = w_key_inv.y;
            end
        end else begin
            n_lane.x = w_data_fwd.x;
            n_lane.y = w_data_fwd.y;
            n_lane.a = w_key_fwd.x;
            n_lane.b = w_key_fwd.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

`default_nettype wire

// ===== rtl/arx_block_cipher_encrypt_decrypt.sv =====
// throughput: one word per cycle, set by the chain of one-round cells
// ROUND_COUNT-1 schedule cells then ROUND_COUNT round cells, for both actions
// busy stays low; the receiver cannot stall and results are never held back
// synchronous active-low reset clears the pipeline valid bits and both keys
`default_nettype none

module arx_block_cipher_encrypt_decrypt
    import arx_pkg::*;
#(
    parameter int ROUND_COUNT = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  t_cmd_word            i_cmd,
    output logic                 o_busy,
    output logic                 o_done,
    output t_result_word         o_result,
    input  wire                  i_cfg_valid,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [WORD_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready
);

    localparam int SCHED_CELLS = ROUND_COUNT - 1;
    localparam int LATENCY     = SCHED_CELLS + ROUND_COUNT;

    t_word r_key_low;
    t_word r_key_high;
    logic  w_accept;
    t_lane w_entry;

    logic  w_valid [0:LATENCY];
    t_lane w_lane  [0:LATENCY];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_entry.dec = i_cmd.action;
        w_entry.x   = i_cmd.in_word_high;
        w_entry.y   = i_cmd.in_word_low;
        w_entry.a   = r_key_high;
        w_entry.b   = r_key_low;
    end

    assign w_valid[0] = w_accept;
    assign w_lane[0]  = w_entry;

    for (genvar g = 0; g < SCHED_CELLS; g++) begin : g_sched
        arx_sched_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        arx_round_cell #(
            .ROUND_COUNT (ROUND_COUNT),
            .IDX         (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[SCHED_CELLS+g]),
            .i_lane  (w_lane[SCHED_CELLS+g]),
            .o_valid (w_valid[SCHED_CELLS+g+1]),
            .o_lane  (w_lane[SCHED_CELLS+g+1])
        );
    end

    assign o_done                 = w_valid[LATENCY];
    assign o_result.out_word_low  = w_lane[LATENCY].y;
    assign o_result.out_word_high = w_lane[LATENCY].x;

    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && i_rst_n, LATENCY))
        else $error("done strobe without a matching accepted word");

    a_no_done_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_rst_n, 1))
        else $error("done strobe straight after reset");

    a_accept_enters_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_valid[1])
        else $error("accepted word lost at chain entry");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import arx_pkg::*;

    localparam int ROUNDS = 16;
    localparam int LATENCY = 2 * ROUNDS - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    t_cmd_word            cmd = '0;
    logic                 busy;
    logic                 done;
    t_result_word         result;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    t_word                cfg_data = '0;
    logic                 cfg_ready;

    // key as the block should hold it
    t_word key_lo = '0;
    t_word key_hi = '0;

    t_cmd_word    block_jobs[$];
    t_result_word expected_blocks[$];

    int error_count = 0;
    int stall_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    logic drain_hold = 1'b0;

    arx_block_cipher_encrypt_decrypt #(
        .ROUND_COUNT(ROUNDS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_cmd       (cmd),
        .o_busy      (busy),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [2*WORD_W-1:0] mix_fwd(input t_word hi, input t_word lo,
                                                   input t_word k);
        t_word s;
        s = ({hi[6:0], hi[31:7]} + lo) ^ k;
        return {s, {lo[29:0], lo[31:30]} ^ s};
    endfunction

    function automatic logic [2*WORD_W-1:0] mix_inv(input t_word hi, input t_word lo,
                                                   input t_word k);
        t_word t;
        t_word d;
        t = lo ^ hi;
        t = {t[1:0], t[31:2]};
        d = (hi ^ k) - t;
        return {{d[24:0], d[31:25]}, t};
    endfunction

    function automatic t_result_word cipher_block(input t_cmd_word c, input t_word klo,
                                                  input t_word khi);
        t_word        x;
        t_word        y;
        t_word        a;
        t_word        b;
        t_word        rkey [ROUNDS];
        t_result_word res;
        int           r;
        a = khi;
        b = klo;
        rkey[0] = b;
        for (r = 0; r < ROUNDS - 1; r++) begin
            {a, b} = mix_fwd(a, b, t_word'(r));
            rkey[r + 1] = b;
        end
        x = c.in_word_high;
        y = c.in_word_low;
        if (c.action == ACT_DECRYPT) begin
            for (r = ROUNDS - 1; r >= 0; r--) begin
                {x, y} = mix_inv(x, y, rkey[r]);
            end
        end else begin
            for (r = 0; r < ROUNDS; r++) begin
                {x, y} = mix_fwd(x, y, rkey[r]);
            end
        end
        res.out_word_low = y;
        res.out_word_high = x;
        return res;
    endfunction

    function automatic t_word rand_word();
        int unsigned pos;
        pos = $urandom_range(0, WORD_W - 1);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return t_word'(1) << pos;
            3: return ~(t_word'(1) << pos);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_block(input logic act, input t_word lo, input t_word hi);
        t_cmd_word c;
        c.action = act;
        c.in_word_low = lo;
        c.in_word_high = hi;
        block_jobs.push_back(c);
    endtask

    // a word followed by its inverse under the current key
    task automatic queue_round_trip(input logic act, input t_word lo, input t_word hi);
        t_cmd_word    c;
        t_result_word r;
        c.action = act;
        c.in_word_low = lo;
        c.in_word_high = hi;
        r = cipher_block(c, key_lo, key_hi);
        block_jobs.push_back(c);
        queue_block(act == ACT_ENCRYPT ? ACT_DECRYPT : ACT_ENCRYPT,
                    r.out_word_low, r.out_word_high);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_word val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_KEY_LOW) begin
            key_lo = val;
        end else if (idx == REG_KEY_HIGH) begin
            key_hi = val;
        end
    endtask

    // checked away from the rising edge so that the sender and monitor have settled
    task automatic wait_idle();
        while (block_jobs.size() != 0 || start || expected_blocks.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // sender: bursts of random length with random gaps, now and then a full drain
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_blocks.push_back(cipher_block(cmd, key_lo, key_hi));
            end
            if (!(start && busy)) begin
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                              : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    if ($urandom_range(0, 7) == 0) begin
                        drain_hold = 1'b1;
                    end
                end
                if (drain_hold && expected_blocks.size() == 0) begin
                    drain_hold = 1'b0;
                end
                if (drain_hold || gap_left != 0 || block_jobs.size() == 0) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end
                    start <= 1'b0;
                end else begin
                    cmd <= block_jobs.pop_front();
                    start <= 1'b1;
                    burst_left--;
                end
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_result_word want;
        if (rst_n && done) begin
            if (expected_blocks.size() == 0) begin
                if (error_count < MAX_REPORTS) begin
                    $display("unexpected word: low %h high %h",
                             result.out_word_low, result.out_word_high);
                end
                error_count++;
            end else begin
                want = expected_blocks.pop_front();
                if (result.out_word_low !== want.out_word_low ||
                    result.out_word_high !== want.out_word_high) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("mismatch: low exp %h got %h, high exp %h got %h",
                                 want.out_word_low, result.out_word_low,
                                 want.out_word_high, result.out_word_high);
                    end
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int    phase;
        int    n;
        t_word w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // zero key: extremes, patterns and a round trip
        queue_block(ACT_ENCRYPT, '0, '0);
        queue_block(ACT_DECRYPT, '0, '0);
        queue_block(ACT_ENCRYPT, '1, '1);
        queue_block(ACT_DECRYPT, '1, '1);
        queue_block(ACT_ENCRYPT, 32'haaaaaaaa, 32'h55555555);
        queue_block(ACT_DECRYPT, 32'h55555555, 32'haaaaaaaa);
        queue_block(ACT_ENCRYPT, 32'h00000001, 32'h80000000);
        queue_block(ACT_DECRYPT, 32'h80000000, 32'h00000001);
        queue_round_trip(ACT_ENCRYPT, 32'h01234567, 32'h89abcdef);
        wait_idle();

        // all-ones key, then writes to unused indexes that must change nothing
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_SPARE_A, 32'hdeadbeef);
        write_reg(REG_SPARE_B, $urandom);
        queue_block(ACT_ENCRYPT, '0, '0);
        queue_block(ACT_DECRYPT, '0, '0);
        queue_block(ACT_ENCRYPT, '1, '1);
        queue_block(ACT_DECRYPT, '1, '1);
        queue_round_trip(ACT_DECRYPT, $urandom, $urandom);
        queue_round_trip(ACT_ENCRYPT, $urandom, $urandom);
        wait_idle();

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_KEY_LOW, '0);
                    write_reg(REG_KEY_HIGH, '1);
                end
                1: begin
                    write_reg(REG_KEY_LOW, '1);
                    write_reg(REG_KEY_HIGH, '0);
                end
                default: begin
                    if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_LOW, rand_word());
                    if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_HIGH, rand_word());
                    if ($urandom_range(0, 2) == 0) begin
                        w = $urandom;
                        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, w);
                    end
                end
            endcase
            n = 0;
            while (n < 130) begin
                if ($urandom_range(0, 9) < 3) begin
                    queue_round_trip($urandom_range(0, 1) ? ACT_DECRYPT : ACT_ENCRYPT,
                                     rand_word(), rand_word());
                    n += 2;
                end else begin
                    queue_block($urandom_range(0, 1) ? ACT_DECRYPT : ACT_ENCRYPT,
                                rand_word(), rand_word());
                    n++;
                end
            end
            wait_idle();
        end

        repeat (LATENCY + 8) @(posedge clk);
        if (error_count == 0 && expected_blocks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
